FILE: src/bpfr_pkg.sv
`default_nettype none
package bpfr_pkg;

  // Commands carried in s_tuser.
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_DONE    = 2'd2;

  // Event kinds carried in m_tuser.
  localparam logic [1:0] EV_TALK   = 2'd0;
  localparam logic [1:0] EV_HEADER = 2'd1;
  localparam logic [1:0] EV_SYMBOL = 2'd2;
  localparam logic [1:0] EV_FAIL   = 2'd3;

  localparam logic [7:0] ESC_BYTE      = 8'd16;
  localparam logic [7:0] RAW_SYNC      = 8'd128;
  localparam logic [7:0] RAW_START     = 8'd129;
  localparam logic [7:0] ESC_SYNC      = 8'd192;
  localparam logic [7:0] ESC_START     = 8'd193;
  localparam logic [7:0] ESC_ESC       = 8'd194;
  localparam logic [8:0] SYM_SYNC      = 9'd256;
  localparam logic [8:0] SYM_START     = 9'd257;
  localparam logic [8:0] SYM_BROADCAST = 9'd255;
  localparam logic [7:0] POLL_OK_SUM   = 8'hFF;

  localparam int          ADDR_W       = 6;
  localparam logic [5:0]  ADDR_RESET   = 6'd1;
  localparam logic [0:0]  REG_MY_ADDR  = 1'b0;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_DEVID   = 7'b0000010,
    PH_PCSUM   = 7'b0000100,
    PH_START   = 7'b0001000,
    PH_ADDR    = 7'b0010000,
    PH_LEN     = 7'b0100000,
    PH_PAYLOAD = 7'b1000000
  } phase_t;

  // One decoded step from the unescaper.
  typedef struct packed {
    logic       sym_valid;
    logic       fail;
    logic       done;
    logic [8:0] sym;
  } dec_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] symbol;
    logic [7:0] sender_id;
    logic [8:0] message_length;
    logic [7:0] header_sum;
  } res_t;

endpackage
`default_nettype wire

FILE: src/bpfr_unescape.sv
`default_nettype none
module bpfr_unescape (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [1:0]    cmd,
  input  wire logic [7:0]    raw_byte,
  input  wire logic          in_payload,
  output bpfr_pkg::dec_t     dec
);
  import bpfr_pkg::*;

  logic escape_pending;
  logic escape_pending_next;

  always_comb begin
    dec = '0;
    escape_pending_next = escape_pending;
    case (cmd)
      CMD_TIMEOUT: begin
        dec.fail = 1'b1;
        escape_pending_next = 1'b0;
      end
      CMD_DONE: begin
        dec.done = 1'b1;
        if (in_payload) begin
          escape_pending_next = 1'b0;
        end
      end
      CMD_BYTE: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (raw_byte == ESC_SYNC) begin
            dec.sym_valid = 1'b1;
            dec.sym = {1'b0, RAW_SYNC};
          end else if (raw_byte == ESC_START) begin
            dec.sym_valid = 1'b1;
            dec.sym = {1'b0, RAW_START};
          end else if (raw_byte == ESC_ESC) begin
            dec.sym_valid = 1'b1;
            dec.sym = {1'b0, ESC_BYTE};
          end else begin
            dec.fail = 1'b1;
          end
        end else if (raw_byte == ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else if (raw_byte == RAW_SYNC) begin
          dec.sym_valid = 1'b1;
          dec.sym = SYM_SYNC;
        end else if (raw_byte == RAW_START) begin
          dec.sym_valid = 1'b1;
          dec.sym = SYM_START;
        end else begin
          dec.sym_valid = 1'b1;
          dec.sym = {1'b0, raw_byte};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (step) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/bpfr_parser.sv
`default_nettype none
module bpfr_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire bpfr_pkg::dec_t dec,
  input  wire logic [5:0]    my_address,
  output logic               in_payload,
  output logic               res_valid,
  output bpfr_pkg::res_t     res
);
  import bpfr_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] poll_sum, poll_sum_next;
  logic [7:0] polled_id, polled_id_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] lo;
  logic [7:0] sum_add;

  assign in_payload = (phase == PH_PAYLOAD);
  assign lo = dec.sym[7:0];

  always_comb begin
    phase_next       = phase;
    poll_sum_next    = poll_sum;
    polled_id_next   = polled_id;
    running_sum_next = running_sum;
    res_valid        = 1'b0;
    res              = '0;
    res.sender_id    = polled_id;
    sum_add          = '0;
    if (dec.fail) begin
      if (phase == PH_PAYLOAD) begin
        res_valid = 1'b1;
        res.kind  = EV_FAIL;
      end else begin
        phase_next = PH_HUNT;
      end
    end else if (dec.done) begin
      if (phase == PH_PAYLOAD) begin
        phase_next = PH_HUNT;
      end
    end else if (dec.sym_valid) begin
      unique case (phase)
        PH_HUNT: begin
          if (dec.sym == SYM_SYNC) begin
            phase_next = PH_DEVID;
          end
        end
        PH_DEVID: begin
          polled_id_next = lo;
          poll_sum_next  = lo;
          phase_next     = PH_PCSUM;
        end
        PH_PCSUM: begin
          sum_add       = poll_sum + lo;
          poll_sum_next = sum_add;
          if (sum_add != POLL_OK_SUM) begin
            phase_next = PH_HUNT;
          end else if (polled_id == {2'b00, my_address}) begin
            phase_next = PH_HUNT;
            res_valid  = 1'b1;
            res.kind   = EV_TALK;
          end else begin
            phase_next = PH_START;
          end
        end
        PH_START: begin
          phase_next = (dec.sym == SYM_START) ? PH_ADDR : PH_HUNT;
        end
        PH_ADDR: begin
          running_sum_next = lo;
          // Tokens sit above every possible address, so they never match.
          if (dec.sym == {3'b000, my_address} || dec.sym == SYM_BROADCAST) begin
            phase_next = PH_LEN;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_LEN: begin
          sum_add            = running_sum + lo;
          running_sum_next   = sum_add;
          phase_next         = PH_PAYLOAD;
          res_valid          = 1'b1;
          res.kind           = EV_HEADER;
          res.message_length = dec.sym;
          res.header_sum     = sum_add;
        end
        PH_PAYLOAD: begin
          res_valid  = 1'b1;
          res.kind   = EV_SYMBOL;
          res.symbol = dec.sym;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      poll_sum    <= '0;
      polled_id   <= '0;
      running_sum <= '0;
    end else if (step) begin
      phase       <= phase_next;
      poll_sum    <= poll_sum_next;
      polled_id   <= polled_id_next;
      running_sum <= running_sum_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/bpfr_out_reg.sv
`default_nettype none
module bpfr_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire logic           res_valid,
  input  wire bpfr_pkg::res_t res,
  input  wire logic           m_tready,
  output logic                can_load,
  output logic                m_tvalid,
  output bpfr_pkg::res_t      m_res
);
  import bpfr_pkg::*;

  // The result register may be refilled in the cycle its item leaves.
  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      m_res <= res;
    end
  end

endmodule
`default_nettype wire

FILE: src/bus_poll_frame_receiver.sv
// Path: an accepted input item waits in the input register, which feeds the decode
// and parse logic; that logic loads the result register when the item advances
// (the result register is empty or being drained).
// Throughput: one input item per cycle; s_tready drops only while both the
// input register and the result register are full and m_tready is low.
// Reset (synchronous, active high) returns the parser to the sync hunt, clears
// the escape flag and the sums, empties both registers and sets my_address to 1.
`default_nettype none
module bus_poll_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] raw_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [8:0] symbol, [16:9] sender_id, [25:17] message_length, [33:26] header_sum
  output logic [39:0]      m_tdata,
  output logic [1:0]       m_tuser,   // [1:0] event_kind
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bpfr_pkg::*;

  logic       in_valid;
  logic [1:0] in_cmd;
  logic [7:0] in_byte;
  logic [5:0] my_address;
  logic       advance;
  logic       can_load;
  logic       in_payload;
  logic       res_valid;
  dec_t       dec;
  res_t       res;
  res_t       m_res;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MY_ADDR) ? {26'd0, my_address} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_address <= ADDR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MY_ADDR) begin
      my_address <= pwdata[ADDR_W-1:0];
    end
  end

  // Input register.
  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  bpfr_unescape u_unescape (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .cmd        (in_cmd),
    .raw_byte   (in_byte),
    .in_payload (in_payload),
    .dec        (dec)
  );

  bpfr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .dec        (dec),
    .my_address (my_address),
    .in_payload (in_payload),
    .res_valid  (res_valid),
    .res        (res)
  );

  bpfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .m_tready  (m_tready),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_res     (m_res)
  );

  assign m_tuser = m_res.kind;
  assign m_tdata = {6'd0, m_res.header_sum, m_res.message_length,
                    m_res.sender_id, m_res.symbol};

endmodule
`default_nettype wire

FILE: tb/sv/bus_poll_frame_receiver_tb.sv
`default_nettype none
module bus_poll_frame_receiver_tb;
  import bpfr_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int ITEMS_PER_SETTING = 670;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] raw_byte
  logic [1:0]  s_tuser = 2'd0;   // [1:0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [8:0] symbol, [16:9] sender_id, [25:17] message_length, [33:26] header_sum
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;          // [1:0] event_kind
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  bus_poll_frame_receiver uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Deframer state as the block should hold it.
  phase_t     rx_phase = PH_HUNT;
  logic       esc_pending = 1'b0;
  logic [7:0] poll_sum = 8'd0;
  logic [7:0] polled_id = 8'd0;
  logic [7:0] running_sum = 8'd0;
  logic [5:0] my_addr = ADDR_RESET;

  res_t expected_events[$];
  res_t next_event;
  int   failures = 0;
  int   items_sent = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   quiet_cycles = 0;

  task push_event(input logic [1:0] kind, input logic [8:0] sym, input logic [8:0] len,
                  input logic [7:0] hsum);
    res_t ev;
    ev.kind = kind;
    ev.symbol = sym;
    ev.sender_id = polled_id;
    ev.message_length = len;
    ev.header_sum = hsum;
    expected_events.push_back(ev);
  endtask

  task take_symbol(input logic [8:0] sym);
    logic [7:0] lo;
    lo = sym[7:0];
    case (rx_phase)
      PH_HUNT: if (sym == SYM_SYNC) rx_phase = PH_DEVID;
      PH_DEVID: begin
        polled_id = lo;
        poll_sum = lo;
        rx_phase = PH_PCSUM;
      end
      PH_PCSUM: begin
        poll_sum = poll_sum + lo;
        if (poll_sum != POLL_OK_SUM) begin
          rx_phase = PH_HUNT;
        end else if (polled_id == {2'b00, my_addr}) begin
          rx_phase = PH_HUNT;
          push_event(EV_TALK, 9'd0, 9'd0, 8'd0);
        end else begin
          rx_phase = PH_START;
        end
      end
      PH_START: rx_phase = (sym == SYM_START) ? PH_ADDR : PH_HUNT;
      PH_ADDR: begin
        running_sum = lo;
        // Tokens are 256 and up, so they can never match an address.
        if (sym != {3'b000, my_addr} && sym != SYM_BROADCAST) rx_phase = PH_HUNT;
        else rx_phase = PH_LEN;
      end
      PH_LEN: begin
        running_sum = running_sum + lo;
        rx_phase = PH_PAYLOAD;
        push_event(EV_HEADER, 9'd0, sym, running_sum);
      end
      PH_PAYLOAD: push_event(EV_SYMBOL, sym, 9'd0, 8'd0);
      default: rx_phase = PH_HUNT;
    endcase
  endtask

  task deframe_item(input logic [1:0] cmd, input logic [7:0] b);
    logic [8:0] sym;
    logic       fail;
    logic       have_sym;
    fail = 1'b0;
    have_sym = 1'b0;
    sym = 9'd0;
    case (cmd)
      CMD_TIMEOUT: fail = 1'b1;
      CMD_DONE: begin
        if (rx_phase == PH_PAYLOAD) begin
          rx_phase = PH_HUNT;
          esc_pending = 1'b0;
        end
      end
      CMD_BYTE: begin
        if (esc_pending) begin
          esc_pending = 1'b0;
          have_sym = 1'b1;
          if (b == ESC_SYNC) sym = {1'b0, RAW_SYNC};
          else if (b == ESC_START) sym = {1'b0, RAW_START};
          else if (b == ESC_ESC) sym = {1'b0, ESC_BYTE};
          else begin
            have_sym = 1'b0;
            fail = 1'b1;
          end
        end else if (b == ESC_BYTE) begin
          esc_pending = 1'b1;
        end else begin
          have_sym = 1'b1;
          if (b == RAW_SYNC) sym = SYM_SYNC;
          else if (b == RAW_START) sym = SYM_START;
          else sym = {1'b0, b};
        end
      end
      default: ;
    endcase
    if (fail) begin
      esc_pending = 1'b0;
      if (rx_phase == PH_PAYLOAD) push_event(EV_FAIL, 9'd0, 9'd0, 8'd0);
      else rx_phase = PH_HUNT;
    end
    if (have_sym) take_symbol(sym);
  endtask

  task send_item(input logic [1:0] cmd, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_item(cmd, b);
    items_sent++;
  endtask

  // Sends a decoded symbol as its byte-stuffed form on the wire.
  task send_sym(input logic [8:0] sym);
    if (sym == SYM_SYNC) send_item(CMD_BYTE, RAW_SYNC);
    else if (sym == SYM_START) send_item(CMD_BYTE, RAW_START);
    else if (sym[7:0] == RAW_SYNC) begin
      send_item(CMD_BYTE, ESC_BYTE);
      send_item(CMD_BYTE, ESC_SYNC);
    end else if (sym[7:0] == RAW_START) begin
      send_item(CMD_BYTE, ESC_BYTE);
      send_item(CMD_BYTE, ESC_START);
    end else if (sym[7:0] == ESC_BYTE) begin
      send_item(CMD_BYTE, ESC_BYTE);
      send_item(CMD_BYTE, ESC_ESC);
    end else begin
      send_item(CMD_BYTE, sym[7:0]);
    end
  endtask

  task wait_idle;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_my_address(input logic [5:0] value);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MY_ADDR, 2'b00};
    pwdata <= {26'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    my_addr = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic logic [8:0] rand_sym();
    int r;
    r = $urandom_range(99);
    if (r < 8) return ($urandom_range(1) != 0) ? SYM_START : SYM_SYNC;
    if (r < 14) return {1'b0, RAW_SYNC};
    if (r < 20) return {1'b0, RAW_START};
    if (r < 26) return {1'b0, ESC_BYTE};
    return 9'($urandom_range(255));
  endfunction

  task test_poll_grant;
    send_item(CMD_BYTE, RAW_SYNC);
    send_sym({3'b000, my_addr});
    send_sym(9'd254);
    // Wrong checksum: the poll is dropped.
    send_item(CMD_BYTE, RAW_SYNC);
    send_sym({3'b000, my_addr});
    send_sym(9'd0);
  endtask

  task test_header_and_payload;
    send_item(CMD_BYTE, RAW_SYNC);
    send_sym(9'd7);
    send_sym(9'd248);
    send_sym(SYM_START);
    send_sym(SYM_BROADCAST);
    send_sym(9'd128);
    send_sym(9'd0);
    send_sym(9'd255);
    send_sym(9'd16);
    send_sym(SYM_SYNC);
    send_sym(SYM_START);
    // Timeout in the middle of an escape, then an illegal escaped byte.
    send_item(CMD_BYTE, ESC_BYTE);
    send_item(CMD_TIMEOUT, 8'hFF);
    send_item(CMD_BYTE, ESC_BYTE);
    send_item(CMD_BYTE, 8'h55);
    send_item(CMD_DONE, 8'h00);
  endtask

  task test_stray_commands;
    send_item(2'd3, 8'hAA);
    send_item(CMD_DONE, 8'h00);
    send_item(CMD_TIMEOUT, 8'h00);
  endtask

  task automatic send_frame;
    logic [8:0] dev;
    logic [8:0] csum;
    logic [8:0] addr;
    logic [7:0] b;
    int r;
    int n;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
    send_item(CMD_BYTE, RAW_SYNC);
    r = $urandom_range(99);
    if (r < 20) dev = {3'b000, my_addr};
    else if (r < 30) dev = ($urandom_range(1) != 0) ? SYM_START : SYM_SYNC;
    else dev = rand_sym();
    if ($urandom_range(99) < 4) begin
      send_item(CMD_TIMEOUT, 8'($urandom_range(255)));
      return;
    end
    send_sym(dev);
    if ($urandom_range(99) < 90) csum = {1'b0, 8'hFF - dev[7:0]};
    else csum = rand_sym();
    // A checksum of 0 or 1 may also travel as a token.
    if (csum == 9'd0 && $urandom_range(3) == 0) csum = SYM_SYNC;
    if (csum == 9'd1 && $urandom_range(3) == 0) csum = SYM_START;
    send_sym(csum);
    if (8'(dev[7:0] + csum[7:0]) != POLL_OK_SUM || dev[7:0] == {2'b00, my_addr}) return;
    send_sym(($urandom_range(99) < 90) ? SYM_START : rand_sym());
    r = $urandom_range(99);
    if (r < 40) addr = {3'b000, my_addr};
    else if (r < 80) addr = SYM_BROADCAST;
    else if (r < 90) addr = ($urandom_range(1) != 0) ? SYM_START : SYM_SYNC;
    else addr = 9'($urandom_range(255));
    send_sym(addr);
    send_sym(rand_sym());
    n = $urandom_range(0, 12);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_item(CMD_TIMEOUT, 8'($urandom_range(255)));
      end else if (r < 10) begin
        send_item(CMD_BYTE, ESC_BYTE);
        if ($urandom_range(1) != 0) begin
          send_item(CMD_TIMEOUT, 8'($urandom_range(255)));
        end else begin
          b = 8'($urandom_range(255));
          if (b == ESC_SYNC || b == ESC_START || b == ESC_ESC) b = 8'd0;
          send_item(CMD_BYTE, b);
        end
      end else begin
        send_sym(rand_sym());
      end
    end
    if ($urandom_range(99) < 90) send_item(CMD_DONE, 8'($urandom_range(255)));
  endtask

  task test_random_frames(input logic [5:0] first_addr);
    int target;
    int next_cfg;
    write_my_address(first_addr);
    target = items_sent + ITEMS_PER_SETTING;
    next_cfg = items_sent + 120;
    while (items_sent < target) begin
      send_frame();
      if (items_sent >= next_cfg) begin
        case ($urandom_range(3))
          0: write_my_address(6'd1);
          1: write_my_address(6'd32);
          2: write_my_address(6'd63);
          default: write_my_address(6'($urandom_range(1, 63)));
        endcase
        next_cfg = items_sent + 120;
      end
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: event_kind %0d symbol %0d", m_tuser, m_tdata[8:0]);
        failures++;
      end else begin
        next_event = expected_events.pop_front();
        if (m_tuser != next_event.kind) begin
          $error("event_kind expected %0d actual %0d", next_event.kind, m_tuser);
          failures++;
        end
        if (m_tdata[8:0] != next_event.symbol) begin
          $error("symbol expected %0d actual %0d", next_event.symbol, m_tdata[8:0]);
          failures++;
        end
        if (m_tdata[16:9] != next_event.sender_id) begin
          $error("sender_id expected %0d actual %0d", next_event.sender_id, m_tdata[16:9]);
          failures++;
        end
        if (m_tdata[25:17] != next_event.message_length) begin
          $error("message_length expected %0d actual %0d", next_event.message_length,
                 m_tdata[25:17]);
          failures++;
        end
        if (m_tdata[33:26] != next_event.header_sum) begin
          $error("header_sum expected %0d actual %0d", next_event.header_sum,
                 m_tdata[33:26]);
          failures++;
        end
      end
    end
  end

  // Ends the run if no handshake completes for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idling(15, 68);
    test_poll_grant();
    test_header_and_payload();
    test_stray_commands();
    test_random_frames(6'd32);
    set_idling(68, 15);
    test_random_frames(6'd63);
    set_idling(0, 0);
    test_random_frames(6'd1);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && expected_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
src/bpfr_pkg.sv
src/bpfr_unescape.sv
src/bpfr_parser.sv
src/bpfr_out_reg.sv
src/bus_poll_frame_receiver.sv
tb/sv/bus_poll_frame_receiver_tb.sv
